/* hw/rtl/sss_pkg.sv */
// ----------------------------------------------------------------------------
// sss_pkg
// shared types, register indexes and codes of the servo sweep and slew stepper
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int ANGLE_W     = 10;
    localparam int DEG_W       = 8;
    localparam int TICK_W      = 16;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DIV_CNT_W   = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_STEP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SNAP_STEP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_JITTER_MIN_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_JITTER_MAX_STEP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_MODE     = 3'd7;

    // motion modes (code 3 acts as jitter sweep)
    localparam logic [MODE_W-1:0] MODE_TARGET = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SWEEP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_JITTER = 2'd2;

    // input operation codes
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_TARGET = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_target;
        logic load_draw;
        logic count;
        logic div_start;
        logic div_step;
        logic do_step;
    } sss_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic elapsed;
        logic need_div;
        logic div_last;
        logic has_result;
        logic out_busy;
    } sss_sts_t;

endpackage

/* hw/rtl/sss_item_if.sv */
// ----------------------------------------------------------------------------
// sss_item_if
// input channel: tick or target write transactions
// ----------------------------------------------------------------------------
interface sss_item_if;
    import sss_pkg::*;

    logic             valid;
    logic             ready;
    logic             op;
    logic [DEG_W-1:0] new_target;
    logic [DEG_W-1:0] random_draw;

    modport source (output valid, output op, output new_target, output random_draw,
                    input ready);
    modport sink (input valid, input op, input new_target, input random_draw,
                  output ready);

endinterface

/* hw/rtl/sss_result_if.sv */
// ----------------------------------------------------------------------------
// sss_result_if
// output channel: commanded servo angle after a step
// ----------------------------------------------------------------------------
interface sss_result_if;
    import sss_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] servo_angle;

    modport source (output valid, output servo_angle, input ready);
    modport sink (input valid, input servo_angle, output ready);

endinterface

/* hw/rtl/sss_cfg_if.sv */
// ----------------------------------------------------------------------------
// sss_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface sss_cfg_if;
    import sss_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);

endinterface

/* hw/rtl/sss_ctrl.sv */
// ----------------------------------------------------------------------------
// sss_ctrl
// controller state machine: loads targets, sequences count, modulo and step per tick transaction
// ----------------------------------------------------------------------------
module sss_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_op,
    output logic              item_ready,
    input  sss_pkg::sss_sts_t sts,
    output sss_pkg::sss_cmd_t cmd
);
    import sss_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_COUNT = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_STEP  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item_op == OP_TARGET)
                    begin
                        cmd.load_target = 1'b1;
                    end
                    else
                    begin
                        cmd.load_draw = 1'b1;
                        state_next    = S_COUNT;
                    end
                end
            end
            S_COUNT:
            begin
                cmd.count = 1'b1;
                if (!sts.elapsed)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (!sts.has_result)
                begin
                    state_next = S_IDLE;
                end
                else if (!sts.out_busy)
                begin
                    cmd.do_step = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/sss_dp.sv */
// ----------------------------------------------------------------------------
// sss_dp
// datapath: configuration, motion state, bit-serial modulo and angle update
// ----------------------------------------------------------------------------
module sss_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [sss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [sss_pkg::DEG_W-1:0]          new_target,
    input  logic [sss_pkg::DEG_W-1:0]          random_draw,
    input  logic                               result_ready,
    output logic                               result_valid,
    output logic signed [sss_pkg::ANGLE_W-1:0] servo_angle,
    input  sss_pkg::sss_cmd_t                  cmd,
    output sss_pkg::sss_sts_t                  sts
);
    import sss_pkg::*;

    // configuration
    logic [DEG_W-1:0]  min_angle_reg;
    logic [DEG_W-1:0]  max_angle_reg;
    logic [DEG_W-1:0]  sweep_step_reg;
    logic [DEG_W-1:0]  snap_step_reg;
    logic [DEG_W-1:0]  jit_min_reg;
    logic [DEG_W-1:0]  jit_max_reg;
    logic [TICK_W-1:0] interval_reg;
    logic [MODE_W-1:0] mode_reg;

    // motion state
    logic signed [ANGLE_W-1:0] angle_reg;
    logic                      up_reg;
    logic [TICK_W-1:0]         tick_reg;
    logic [DEG_W-1:0]          target_reg;
    logic [DEG_W-1:0]          draw_reg;

    // modulo unit
    logic [DEG_W:0]         rem_reg;
    logic [DEG_W-1:0]       shift_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [DEG_W:0]         span;
    logic [DEG_W:0]         trial;
    logic                   jit_ok;

    // output register
    logic                      out_valid_reg;
    logic signed [ANGLE_W-1:0] out_angle_reg;

    // step logic
    logic [TICK_W-1:0]         tick_sat;
    logic signed [ANGLE_W:0]   cur_w;
    logic signed [ANGLE_W:0]   min_w;
    logic signed [ANGLE_W:0]   max_w;
    logic signed [ANGLE_W:0]   snap_w;
    logic signed [ANGLE_W:0]   diff;
    logic signed [ANGLE_W:0]   amount;
    logic signed [ANGLE_W:0]   inc;
    logic signed [ANGLE_W+1:0] sum;
    logic signed [ANGLE_W-1:0] angle_new;
    logic                      up_eff;
    logic                      is_target;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_angle_reg  <= 8'd0;
            max_angle_reg  <= 8'd180;
            sweep_step_reg <= 8'd1;
            snap_step_reg  <= 8'd1;
            jit_min_reg    <= 8'd1;
            jit_max_reg    <= 8'd4;
            interval_reg   <= 16'd20;
            mode_reg       <= MODE_TARGET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MIN_ANGLE:       min_angle_reg  <= cfg_data[DEG_W-1:0];
                REG_MAX_ANGLE:       max_angle_reg  <= cfg_data[DEG_W-1:0];
                REG_SWEEP_STEP:      sweep_step_reg <= cfg_data[DEG_W-1:0];
                REG_SNAP_STEP:       snap_step_reg  <= cfg_data[DEG_W-1:0];
                REG_JITTER_MIN_STEP: jit_min_reg    <= cfg_data[DEG_W-1:0];
                REG_JITTER_MAX_STEP: jit_max_reg    <= cfg_data[DEG_W-1:0];
                REG_STEP_INTERVAL:   interval_reg   <= cfg_data[TICK_W-1:0];
                REG_MOTION_MODE:     mode_reg       <= cfg_data[MODE_W-1:0];
                default:             ;
            endcase
        end
    end

    // tick counter, saturating
    assign tick_sat    = (tick_reg == {TICK_W{1'b1}}) ? tick_reg : tick_reg + 1'b1;
    assign sts.elapsed = (tick_sat > interval_reg);

    // jitter span and one restoring step per cycle
    assign jit_ok       = (jit_max_reg >= jit_min_reg);
    assign span         = {1'b0, jit_max_reg} - {1'b0, jit_min_reg} + 1'b1;
    assign trial        = {rem_reg[DEG_W-1:0], shift_reg[DEG_W-1]};
    assign sts.need_div = mode_reg[1] && jit_ok;
    assign sts.div_last = (div_cnt_reg == {DIV_CNT_W{1'b1}});

    // step arithmetic
    assign is_target = (mode_reg == MODE_TARGET);
    assign cur_w     = {angle_reg[ANGLE_W-1], angle_reg};
    assign min_w     = $signed({3'b000, min_angle_reg});
    assign max_w     = $signed({3'b000, max_angle_reg});
    assign snap_w    = $signed({3'b000, snap_step_reg});
    assign diff      = $signed({3'b000, target_reg}) - cur_w;

    always_comb
    begin
        // lower bound check overrides the upper one
        if (cur_w <= min_w)
        begin
            up_eff = 1'b1;
        end
        else if (cur_w >= max_w)
        begin
            up_eff = 1'b0;
        end
        else
        begin
            up_eff = up_reg;
        end

        if (mode_reg == MODE_SWEEP)
        begin
            amount = $signed({3'b000, sweep_step_reg});
        end
        else if (jit_ok)
        begin
            amount = $signed({3'b000, jit_min_reg}) + $signed({3'b000, rem_reg[DEG_W-1:0]});
        end
        else
        begin
            amount = $signed({3'b000, jit_min_reg});
        end

        if (is_target)
        begin
            if (diff > snap_w)
            begin
                inc = snap_w;
            end
            else if (diff < -snap_w)
            begin
                inc = -snap_w;
            end
            else
            begin
                inc = diff;
            end
        end
        else
        begin
            inc = up_eff ? amount : -amount;
        end

        sum = {cur_w[ANGLE_W], cur_w} + {inc[ANGLE_W], inc};
        if (sum < -12'sd512)
        begin
            angle_new = -10'sd512;
        end
        else if (sum > 12'sd511)
        begin
            angle_new = 10'sd511;
        end
        else
        begin
            angle_new = sum[ANGLE_W-1:0];
        end
    end

    assign sts.has_result = !is_target || (diff != '0);
    assign sts.out_busy   = out_valid_reg && !result_ready;

    // motion state and modulo unit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg   <= '0;
            up_reg      <= 1'b1;
            tick_reg    <= '0;
            target_reg  <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.load_target)
            begin
                target_reg <= new_target;
            end
            if (cmd.count)
            begin
                tick_reg <= sts.elapsed ? '0 : tick_sat;
            end
            if (cmd.div_start)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.do_step)
            begin
                angle_reg <= angle_new;
                if (!is_target)
                begin
                    up_reg <= up_eff;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_draw)
        begin
            draw_reg <= random_draw;
        end
        if (cmd.div_start)
        begin
            rem_reg   <= '0;
            shift_reg <= draw_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg   <= (trial >= span) ? trial - span : trial;
            shift_reg <= {shift_reg[DEG_W-2:0], 1'b0};
        end
        if (cmd.do_step)
        begin
            out_angle_reg <= angle_new;
        end
    end

    // result holding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.do_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign servo_angle  = out_angle_reg;

endmodule

/* hw/rtl/servo_sweep_and_slew_stepper.sv */
// ----------------------------------------------------------------------------
// servo_sweep_and_slew_stepper
// tick driven servo angle stepper with sweep, jitter sweep and target slew
// ----------------------------------------------------------------------------
// usage
//   item   : one transaction per millisecond tick (op 0) or target write (op 1)
//   result : the new servo angle, one transaction per step taken
//   cfg    : register writes, always ready; the user must write only while the
//            block is idle, which the block itself never enforces
// sequence per item
//   target write      : accept and load, no result
//   tick              : accept, counter update, any due step to the result register
//   jitter step       : the bit-serial modulo (8 steps) runs before the step
//   the next item is taken while a finished result still waits
// reset
//   config takes its documented reset values, angle 0, direction up,
//   tick counter 0, target 0, no result pending
// stall
//   a step waits in the controller until the result register is free;
//   items are not accepted during that wait
// ----------------------------------------------------------------------------
module servo_sweep_and_slew_stepper (
    input  logic         clk,
    input  logic         rst_n,
    sss_item_if.sink     item,
    sss_result_if.source result,
    sss_cfg_if.sink      cfg
);
    import sss_pkg::*;

    sss_cmd_t cmd;
    sss_sts_t sts;

    // config port never stalls
    assign cfg.ready = 1'b1;

    // controller: sequences each accepted transaction
    sss_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_op    (item.op),
        .item_ready (item.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // datapath: registers, modulo unit and output register
    sss_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .new_target   (item.new_target),
        .random_draw  (item.random_draw),
        .result_ready (result.ready),
        .result_valid (result.valid),
        .servo_angle  (result.servo_angle),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

/* tb/servo_sweep_and_slew_stepper_tb.sv */
// ----------------------------------------------------------------------------
// servo_sweep_and_slew_stepper_tb
// self-checking bench for the tick driven servo angle stepper
// ----------------------------------------------------------------------------
// a short directed table covers the target slew corners, sweep reversal at
// the range ends, wide and reversed jitter bounds, the spare mode code and
// the largest interval, then random phases follow; each phase reprogrammes
// every register while the block is idle and then sends random ticks and
// target writes; a local copy of the stepper state predicts every angle and
// each result transaction is checked in order; both channels idle at random
// ----------------------------------------------------------------------------
module servo_sweep_and_slew_stepper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sss_pkg::*;

    // spare mode code, the block treats it as jitter sweep
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int ANGLE_LO      = -(1 << (ANGLE_W - 1));
    localparam int ANGLE_HI      = (1 << (ANGLE_W - 1)) - 1;
    localparam int RANDOM_ITEMS  = 1150;
    // longest internal step (jitter modulo) plus margin
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DIRECTED_ROWS = 42;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;
    // how a directed row is checked: by the predictor, by a typed angle, or no result
    typedef enum logic [1:0] {CHK_MODEL, CHK_ANGLE, CHK_NONE} row_check_t;

    typedef struct packed {
        row_kind_t                 kind;
        row_check_t                chk;
        logic                      op;
        logic [DEG_W-1:0]          tgt;
        logic [DEG_W-1:0]          draw;
        logic [CFG_IDX_W-1:0]      reg_idx;
        logic [CFG_DATA_W-1:0]     reg_data;
        logic signed [ANGLE_W-1:0] angle;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sss_item_if   item_ch ();
    sss_result_if result_ch ();
    sss_cfg_if    cfg_ch ();

    servo_sweep_and_slew_stepper u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // predicted register contents, at their reset values
    logic [DEG_W-1:0]  min_deg   = 8'd0;
    logic [DEG_W-1:0]  max_deg   = 8'd180;
    logic [DEG_W-1:0]  sweep_deg = 8'd1;
    logic [DEG_W-1:0]  snap_deg  = 8'd1;
    logic [DEG_W-1:0]  jit_lo    = 8'd1;
    logic [DEG_W-1:0]  jit_hi    = 8'd4;
    logic [TICK_W-1:0] interval  = 16'd20;
    logic [MODE_W-1:0] mode      = MODE_TARGET;

    // predicted stepper state
    logic signed [ANGLE_W-1:0] angle_now  = '0;
    logic                      going_up   = 1'b1;
    logic [TICK_W-1:0]         ticks      = '0;
    logic [DEG_W-1:0]          target_deg = '0;

    // angles still owed by the block, oldest first
    logic signed [ANGLE_W-1:0] expected_angles [$];

    int  fail_count     = 0;
    int  items_sent     = 0;
    int  targets_sent   = 0;
    int  angles_checked = 0;
    int  reg_writes     = 0;
    int  phases_run     = 0;
    int  cycles         = 0;
    int  stall_left     = 0;
    bit  rx_calm        = 1'b0;

    // directed table: corners of the slew, sweep and jitter behaviour
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // target slew from reset: one degree, then the remaining 254 degrees within one snap, then target reached
        '{ROW_ITEM, CHK_NONE,  OP_TARGET, 8'd255, 8'd0,   REG_MIN_ANGLE,       16'd0,   10'sd0},
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_STEP_INTERVAL,   16'd0,   10'sd0},
        '{ROW_ITEM, CHK_ANGLE, OP_TICK,   8'd0,   8'd0,   REG_MIN_ANGLE,       16'd0,   10'sd1},
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_SNAP_STEP,       16'd255, 10'sd0},
        '{ROW_ITEM, CHK_ANGLE, OP_TICK,   8'd0,   8'd255, REG_MIN_ANGLE,       16'd0,   10'sd255},
        '{ROW_ITEM, CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_MIN_ANGLE,       16'd0,   10'sd0},
        // zero snap step still reports the unchanged angle
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_SNAP_STEP,       16'd0,   10'sd0},
        '{ROW_ITEM, CHK_NONE,  OP_TARGET, 8'd0,   8'd0,   REG_MIN_ANGLE,       16'd0,   10'sd0},
        '{ROW_ITEM, CHK_ANGLE, OP_TICK,   8'd0,   8'd0,   REG_MIN_ANGLE,       16'd0,   10'sd255},
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_SNAP_STEP,       16'd255, 10'sd0},
        '{ROW_ITEM, CHK_ANGLE, OP_TICK,   8'd0,   8'd0,   REG_MIN_ANGLE,       16'd0,   10'sd0},
        // plain sweep with the widest step bounces between the range ends
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_MOTION_MODE,
          16'(MODE_SWEEP), 10'sd0},
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_SWEEP_STEP,      16'd255, 10'sd0},
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_MAX_ANGLE,       16'd255, 10'sd0},
        '{ROW_ITEM, CHK_ANGLE, OP_TICK,   8'd0,   8'd0,   REG_MIN_ANGLE,       16'd0,   10'sd255},
        '{ROW_ITEM, CHK_ANGLE, OP_TICK,   8'd0,   8'd0,   REG_MIN_ANGLE,       16'd0,   10'sd0},
        // lower bound at its top: the angle lies below it, so the sweep turns upward
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_MIN_ANGLE,       16'd255, 10'sd0},
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_SWEEP_STEP,      16'd1,   10'sd0},
        '{ROW_ITEM, CHK_MODEL, OP_TICK,   8'd0,   8'd0,   REG_MIN_ANGLE,       16'd0,   10'sd0},
        // jitter over the full draw range
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_MOTION_MODE,
          16'(MODE_JITTER), 10'sd0},
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_JITTER_MIN_STEP, 16'd0,   10'sd0},
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_JITTER_MAX_STEP, 16'd255, 10'sd0},
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_MIN_ANGLE,       16'd0,   10'sd0},
        '{ROW_ITEM, CHK_MODEL, OP_TICK,   8'd0,   8'd255, REG_MIN_ANGLE,       16'd0,   10'sd0},
        '{ROW_ITEM, CHK_MODEL, OP_TICK,   8'd0,   8'd128, REG_MIN_ANGLE,       16'd0,   10'sd0},
        // reversed jitter bounds fall back to the lower bound, angle goes negative
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_JITTER_MIN_STEP, 16'd200, 10'sd0},
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_JITTER_MAX_STEP, 16'd100, 10'sd0},
        '{ROW_ITEM, CHK_MODEL, OP_TICK,   8'd0,   8'd77,  REG_MIN_ANGLE,       16'd0,   10'sd0},
        // spare mode code acts as jitter sweep
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_MOTION_MODE,
          16'(MODE_SPARE), 10'sd0},
        '{ROW_ITEM, CHK_MODEL, OP_TICK,   8'd0,   8'd255, REG_MIN_ANGLE,       16'd0,   10'sd0},
        // largest interval: the counter can never pass it
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_STEP_INTERVAL,   16'hFFFF, 10'sd0},
        '{ROW_ITEM, CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_MIN_ANGLE,       16'd0,   10'sd0},
        '{ROW_ITEM, CHK_NONE,  OP_TICK,   8'd0,   8'd170, REG_MIN_ANGLE,       16'd0,   10'sd0},
        '{ROW_ITEM, CHK_NONE,  OP_TICK,   8'd0,   8'd85,  REG_MIN_ANGLE,       16'd0,   10'sd0},
        // short interval, a target write mid count leaves the counter alone
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_STEP_INTERVAL,   16'd2,   10'sd0},
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_MOTION_MODE,
          16'(MODE_SWEEP), 10'sd0},
        '{ROW_CFG,  CHK_NONE,  OP_TICK,   8'd0,   8'd0,   REG_SWEEP_STEP,      16'd5,   10'sd0},
        '{ROW_ITEM, CHK_MODEL, OP_TICK,   8'd0,   8'd0,   REG_MIN_ANGLE,       16'd0,   10'sd0},
        '{ROW_ITEM, CHK_MODEL, OP_TICK,   8'd0,   8'd0,   REG_MIN_ANGLE,       16'd0,   10'sd0},
        '{ROW_ITEM, CHK_MODEL, OP_TARGET, 8'd40,  8'd0,   REG_MIN_ANGLE,       16'd0,   10'sd0},
        '{ROW_ITEM, CHK_MODEL, OP_TICK,   8'd0,   8'd0,   REG_MIN_ANGLE,       16'd0,   10'sd0},
        '{ROW_ITEM, CHK_MODEL, OP_TICK,   8'd0,   8'd0,   REG_MIN_ANGLE,       16'd0,   10'sd0}
    };

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run guard
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d angles outstanding",
                     cycles, expected_angles.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side back-pressure: mostly ready, short stalls, the odd long one
    always @(posedge clk) begin
        int r;
        if (stall_left > 0) begin
            result_ch.ready <= 1'b0;
            stall_left--;
        end
        else begin
            r = $urandom_range(0, 99);
            if (rx_calm || r < 75) begin
                result_ch.ready <= 1'b1;
            end
            else begin
                result_ch.ready <= 1'b0;
                stall_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(9, 39);
            end
        end
    end

    // result monitor: every angle transaction against the oldest prediction
    always @(posedge clk) begin
        logic signed [ANGLE_W-1:0] want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_angles.size() == 0) begin
                $error("servo_angle: expected no transaction, got %0d", result_ch.servo_angle);
                fail_count++;
            end
            else begin
                want = expected_angles.pop_front();
                if (result_ch.servo_angle !== want) begin
                    $error("servo_angle: expected %0d, got %0d", want, result_ch.servo_angle);
                    fail_count++;
                end
                angles_checked++;
            end
        end
    end

    // one tick or target write through the stepper, mirrors the block's behaviour
    task automatic step_stepper(input logic op, input logic [DEG_W-1:0] tgt,
                                input logic [DEG_W-1:0] draw, output bit stepped,
                                output logic signed [ANGLE_W-1:0] angle);
        int diff;
        int lim;
        int amount;
        int inc;
        int nxt;
        stepped = 1'b0;
        angle   = '0;
        inc     = 0;
        if (op == OP_TARGET) begin
            target_deg = tgt;
        end
        else begin
            if (ticks != '1)
                ticks = ticks + 1'b1;
            if (ticks > interval) begin
                ticks = '0;
                if (mode == MODE_TARGET) begin
                    diff = int'(target_deg) - int'(angle_now);
                    lim  = int'(snap_deg);
                    if (diff > lim)
                        inc = lim;
                    else if (diff < -lim)
                        inc = -lim;
                    else
                        inc = diff;
                    // target reached: counter restarts but nothing is reported
                    stepped = (diff != 0);
                end
                else begin
                    if (int'(angle_now) >= int'(max_deg))
                        going_up = 1'b0;
                    if (int'(angle_now) <= int'(min_deg))
                        going_up = 1'b1;
                    if (mode == MODE_SWEEP)
                        amount = int'(sweep_deg);
                    else if (jit_hi < jit_lo)
                        amount = int'(jit_lo);
                    else
                        amount = int'(jit_lo) + int'(draw) % (int'(jit_hi) - int'(jit_lo) + 1);
                    inc     = going_up ? amount : -amount;
                    stepped = 1'b1;
                end
                if (stepped) begin
                    nxt = int'(angle_now) + inc;
                    if (nxt < ANGLE_LO)
                        nxt = ANGLE_LO;
                    else if (nxt > ANGLE_HI)
                        nxt = ANGLE_HI;
                    angle_now = ANGLE_W'(nxt);
                    angle     = angle_now;
                end
            end
        end
    endtask

    // leaves cfg valid high; the caller drops it once the batch is done
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_MIN_ANGLE:       min_deg   = val[DEG_W-1:0];
            REG_MAX_ANGLE:       max_deg   = val[DEG_W-1:0];
            REG_SWEEP_STEP:      sweep_deg = val[DEG_W-1:0];
            REG_SNAP_STEP:       snap_deg  = val[DEG_W-1:0];
            REG_JITTER_MIN_STEP: jit_lo    = val[DEG_W-1:0];
            REG_JITTER_MAX_STEP: jit_hi    = val[DEG_W-1:0];
            REG_STEP_INTERVAL:   interval  = val[TICK_W-1:0];
            REG_MOTION_MODE:     mode      = val[MODE_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // one item transaction; valid stays high afterwards unless a gap follows
    task automatic put_item(input logic op, input logic [DEG_W-1:0] tgt,
                            input logic [DEG_W-1:0] draw, input int gap,
                            input row_check_t chk, input logic signed [ANGLE_W-1:0] typed);
        bit                        stepped;
        logic signed [ANGLE_W-1:0] angle;
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.op          <= op;
        item_ch.new_target  <= tgt;
        item_ch.random_draw <= draw;
        do @(posedge clk); while (!item_ch.ready);
        step_stepper(op, tgt, draw, stepped, angle);
        case (chk)
            CHK_MODEL: if (stepped) expected_angles.push_back(angle);
            CHK_ANGLE: expected_angles.push_back(typed);
            default: ;
        endcase
        items_sent++;
        if (op == OP_TARGET)
            targets_sent++;
    endtask

    // stop sending, let every owed angle arrive, then let the block settle
    task automatic wait_quiet();
        item_ch.valid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // degrees biased towards both ends of the byte
    function automatic logic [DEG_W-1:0] pick_deg();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return DEG_W'($urandom_range(0, 255));
    endfunction

    // sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // new register set for a random phase, written once the block is idle
    task automatic program_phase(input bit slow_phase);
        logic [DEG_W-1:0]  lo_a;
        logic [DEG_W-1:0]  hi_a;
        logic [DEG_W-1:0]  swp;
        logic [DEG_W-1:0]  snp;
        logic [DEG_W-1:0]  j_lo;
        logic [DEG_W-1:0]  j_hi;
        logic [TICK_W-1:0] gap_ticks;
        logic [MODE_W-1:0] md;
        int                r;
        // usually an ordinary range, sometimes corners or reversed bounds
        if ($urandom_range(0, 9) < 7) begin
            lo_a = DEG_W'($urandom_range(0, 90));
            hi_a = DEG_W'($urandom_range(90, 255));
        end
        else begin
            lo_a = pick_deg();
            hi_a = pick_deg();
        end
        swp = ($urandom_range(0, 4) == 0) ? pick_deg() : DEG_W'($urandom_range(1, 20));
        snp = ($urandom_range(0, 4) == 0) ? pick_deg() : DEG_W'($urandom_range(1, 30));
        if ($urandom_range(0, 3) == 0) begin
            j_lo = pick_deg();
            j_hi = pick_deg();
        end
        else begin
            j_lo = DEG_W'($urandom_range(0, 10));
            j_hi = DEG_W'($urandom_range(j_lo, j_lo + 20));
        end
        r = $urandom_range(0, 99);
        if (slow_phase)
            gap_ticks = '1;
        else if (r < 50)
            gap_ticks = TICK_W'($urandom_range(0, 2));
        else if (r < 88)
            gap_ticks = TICK_W'($urandom_range(3, 12));
        else
            gap_ticks = TICK_W'($urandom_range(13, 40));
        md = MODE_W'($urandom_range(0, 3));
        wait_quiet();
        write_reg(REG_MIN_ANGLE, CFG_DATA_W'(lo_a));
        write_reg(REG_MAX_ANGLE, CFG_DATA_W'(hi_a));
        write_reg(REG_SWEEP_STEP, CFG_DATA_W'(swp));
        write_reg(REG_SNAP_STEP, CFG_DATA_W'(snp));
        write_reg(REG_JITTER_MIN_STEP, CFG_DATA_W'(j_lo));
        write_reg(REG_JITTER_MAX_STEP, CFG_DATA_W'(j_hi));
        write_reg(REG_STEP_INTERVAL, CFG_DATA_W'(gap_ticks));
        write_reg(REG_MOTION_MODE, CFG_DATA_W'(md));
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        stim_row_t        row;
        bit               cfg_open;
        bit               slow;
        bit               tx_calm;
        int               n_items;
        int               random_sent;
        int               gap;
        logic             op;

        // everything known from time zero, with reset held low
        rst_n               = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.op          = OP_TICK;
        item_ch.new_target  = '0;
        item_ch.random_draw = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_MIN_ANGLE;
        cfg_ch.data         = '0;
        result_ch.ready     = 1'b0;
        cfg_open            = 1'b0;
        random_sent         = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, register rows grouped into one idle window
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG) begin
                if (!cfg_open)
                    wait_quiet();
                write_reg(row.reg_idx, row.reg_data);
                cfg_open = 1'b1;
            end
            else begin
                if (cfg_open) begin
                    cfg_ch.valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                put_item(row.op, row.tgt, row.draw, 0, row.chk, row.angle);
            end
        end

        // random phases; one early phase runs with the largest interval
        while (random_sent < RANDOM_ITEMS) begin
            slow = (phases_run == 3);
            program_phase(slow);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            n_items = slow ? 8 : $urandom_range(30, 70);
            for (int k = 0; k < n_items; k++) begin
                // now and then hold off until the block has emptied
                if ($urandom_range(0, 39) == 0)
                    wait_quiet();
                gap = tx_calm ? 0 : pick_gap();
                op  = ($urandom_range(0, 99) < 18) ? OP_TARGET : OP_TICK;
                put_item(op, pick_deg(), DEG_W'($urandom_range(0, 255)), gap, CHK_MODEL, '0);
                random_sent++;
            end
            phases_run++;
        end

        wait_quiet();
        $display("sent %0d item transactions (%0d target writes), checked %0d angles",
                 items_sent, targets_sent, angles_checked);
        $display("made %0d register writes across %0d random phases", reg_writes, phases_run);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
